@@ src/tgc_pkg.sv @@
// Shared types and constants of the thresholded gray centroid block.
// No dependencies; imported by tgc_ctrl, tgc_datapath and the top level.
package tgc_pkg;

   localparam int INT_W = 30;
   localparam int WSUM_W = 41;
   localparam int COORD_W = 11;
   localparam int GRAY_SUM_W = 22;
   localparam int GRAY_SHIFT = 14;

   localparam logic [13:0] GRAY_WB = 14'd1868;
   localparam logic [13:0] GRAY_WG = 14'd9617;
   localparam logic [13:0] GRAY_WR = 14'd4899;
   localparam logic [13:0] GRAY_ROUND = 14'd8192;

   localparam logic [7:0] THRESHOLD_RST = 8'd20;
   localparam logic [11:0] FRAME_WIDTH_RST = 12'd640;

   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_FRAME_WIDTH = 1'b1;

   localparam int DIV_STEPS = WSUM_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef struct packed {
      logic accept;
      logic div_load;
      logic div_sel_y;
      logic div_step;
      logic cap_x;
      logic cap_y;
      logic cap_dark;
      logic clear_sums;
   } cmd_type;

   typedef struct packed {
      logic dark;
      logic div_last;
   } status_type;

endpackage

@@ src/tgc_ctrl.sv @@
// Controller of the thresholded gray centroid block: frame and division sequencing.
// Depends on tgc_pkg.
module tgc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tlast,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  tgc_pkg::status_type status,
   output tgc_pkg::cmd_type    cmd
);
   import tgc_pkg::*;

   localparam logic [2:0] ST_ACC   = 3'd0;
   localparam logic [2:0] ST_FLUSH = 3'd1;
   localparam logic [2:0] ST_LOADX = 3'd2;
   localparam logic [2:0] ST_DIVX  = 3'd3;
   localparam logic [2:0] ST_LOADY = 3'd4;
   localparam logic [2:0] ST_DIVY  = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      req_tready = (state_ff == ST_ACC);
      rsp_tvalid = (state_ff == ST_OUT);
      cmd.accept = req_tready & req_tvalid;
      unique case (state_ff)
         ST_ACC: begin
            if (cmd.accept && req_tlast) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            state_in = ST_LOADX;
         end
         ST_LOADX: begin
            if (status.dark) begin
               cmd.cap_dark = 1'b1;
               cmd.clear_sums = 1'b1;
               state_in = ST_OUT;
            end else begin
               cmd.div_load = 1'b1;
               state_in = ST_DIVX;
            end
         end
         ST_DIVX: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_LOADY;
         end
         ST_LOADY: begin
            cmd.cap_x = 1'b1;
            cmd.div_load = 1'b1;
            cmd.div_sel_y = 1'b1;
            state_in = ST_DIVY;
         end
         ST_DIVY: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.cap_y = 1'b1;
            cmd.clear_sums = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) state_in = ST_ACC;
         end
         default: state_in = ST_ACC;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACC;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/tgc_datapath.sv @@
// Datapath of the thresholded gray centroid block: gray conversion, counters,
// saturating sums, shared restoring divider and result register. Depends on tgc_pkg.
module tgc_datapath #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                clock,
   input  logic                reset,
   input  tgc_pkg::cmd_type    cmd,
   output tgc_pkg::status_type status,
   input  logic                csr_we,
   input  logic                csr_addr,
   input  logic [11:0]         csr_wdata,
   input  logic [7:0]          blue,
   input  logic [7:0]          green,
   input  logic [7:0]          red,
   input  logic                last_pixel,
   output logic [tgc_pkg::COORD_W-1:0] center_x,
   output logic [tgc_pkg::COORD_W-1:0] center_y,
   output logic                dark_frame
);
   import tgc_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int WW = (CW + 1 > 12) ? CW + 1 : 12;
   localparam logic [WW-1:0] WIDTH_MAX = WW'(MAX_WIDTH);
   localparam logic [RW-1:0] ROW_MAX = RW'(MAX_HEIGHT - 1);
   localparam logic [WSUM_W-1:0] XMAX = WSUM_W'(MAX_WIDTH - 1);
   localparam logic [WSUM_W-1:0] YMAX = WSUM_W'(MAX_HEIGHT - 1);

   logic [7:0]  thr_ff;
   logic [11:0] fw_ff;

   logic [CW-1:0] col_ff;
   logic [CW-1:0] col_in;
   logic [RW-1:0] row_ff;
   logic [RW-1:0] row_in;
   logic [WW-1:0] width_eff;

   logic [GRAY_SUM_W-1:0] gray_sum;
   logic [7:0] gray_raw;
   logic [7:0] gray_thr;

   logic          acc_vld_ff;
   logic [7:0]    gray_ff;
   logic [CW-1:0] gcol_ff;
   logic [RW-1:0] grow_ff;

   logic [INT_W-1:0]  it_ff;
   logic [WSUM_W-1:0] cw_ff;
   logic [WSUM_W-1:0] rw_ff;
   logic [INT_W:0]    it_sum;
   logic [WSUM_W:0]   cw_sum;
   logic [WSUM_W:0]   rw_sum;
   logic [CW+7:0]     cprod;
   logic [RW+7:0]     rprod;

   logic [WSUM_W-1:0]    div_q_ff;
   logic [INT_W-1:0]     div_r_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [INT_W:0]       div_rsh;
   logic                 div_ge;
   logic [INT_W:0]       div_diff;

   logic [COORD_W-1:0] cx_ff;
   logic [COORD_W-1:0] cy_ff;
   logic               dark_ff;
   logic [WSUM_W-1:0]  xq_clamp;
   logic [WSUM_W-1:0]  yq_clamp;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RST;
         fw_ff <= FRAME_WIDTH_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_THRESHOLD:   thr_ff <= csr_wdata[7:0];
            CSR_FRAME_WIDTH: fw_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // gray conversion and threshold
   always_comb begin
      gray_sum = GRAY_SUM_W'(GRAY_WB) * GRAY_SUM_W'(blue)
               + GRAY_SUM_W'(GRAY_WG) * GRAY_SUM_W'(green)
               + GRAY_SUM_W'(GRAY_WR) * GRAY_SUM_W'(red)
               + GRAY_SUM_W'(GRAY_ROUND);
      gray_raw = gray_sum[GRAY_SHIFT+7:GRAY_SHIFT];
      gray_thr = (gray_raw < thr_ff) ? 8'd0 : gray_raw;
   end

   // raster counters
   always_comb begin
      if (fw_ff == 12'd0) begin
         width_eff = WW'(1);
      end else if (WW'(fw_ff) > WIDTH_MAX) begin
         width_eff = WIDTH_MAX;
      end else begin
         width_eff = WW'(fw_ff);
      end
      col_in = col_ff;
      row_in = row_ff;
      if (cmd.accept) begin
         if (last_pixel) begin
            col_in = '0;
            row_in = '0;
         end else if (WW'(col_ff) + WW'(1) >= width_eff) begin
            col_in = '0;
            if (row_ff < ROW_MAX) row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         acc_vld_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         acc_vld_ff <= cmd.accept;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         gray_ff <= gray_thr;
         gcol_ff <= col_ff;
         grow_ff <= row_ff;
      end
   end

   // saturating sums
   always_comb begin
      cprod = (CW+8)'(gcol_ff) * (CW+8)'(gray_ff);
      rprod = (RW+8)'(grow_ff) * (RW+8)'(gray_ff);
      it_sum = {1'b0, it_ff} + (INT_W+1)'(gray_ff);
      cw_sum = {1'b0, cw_ff} + (WSUM_W+1)'(cprod);
      rw_sum = {1'b0, rw_ff} + (WSUM_W+1)'(rprod);
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_sums) begin
         it_ff <= '0;
         cw_ff <= '0;
         rw_ff <= '0;
      end else if (acc_vld_ff) begin
         it_ff <= it_sum[INT_W] ? '1 : it_sum[INT_W-1:0];
         cw_ff <= cw_sum[WSUM_W] ? '1 : cw_sum[WSUM_W-1:0];
         rw_ff <= rw_sum[WSUM_W] ? '1 : rw_sum[WSUM_W-1:0];
      end
   end

   // restoring divider, one quotient bit per cycle
   always_comb begin
      div_rsh = {div_r_ff, div_q_ff[WSUM_W-1]};
      div_diff = div_rsh - {1'b0, it_ff};
      div_ge = (div_rsh >= {1'b0, it_ff});
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         div_q_ff <= cmd.div_sel_y ? rw_ff : cw_ff;
         div_r_ff <= '0;
         div_cnt_ff <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (cmd.div_step) begin
         div_q_ff <= {div_q_ff[WSUM_W-2:0], div_ge};
         div_r_ff <= div_ge ? div_diff[INT_W-1:0] : div_rsh[INT_W-1:0];
         div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
      end
   end

   always_comb begin
      status.dark = (it_ff == '0);
      status.div_last = (div_cnt_ff == '0);
   end

   // result register
   always_comb begin
      xq_clamp = (div_q_ff > XMAX) ? XMAX : div_q_ff;
      yq_clamp = (div_q_ff > YMAX) ? YMAX : div_q_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_dark) begin
         cx_ff <= '0;
         cy_ff <= '0;
         dark_ff <= 1'b1;
      end else begin
         if (cmd.cap_x) cx_ff <= xq_clamp[COORD_W-1:0];
         if (cmd.cap_y) begin
            cy_ff <= yq_clamp[COORD_W-1:0];
            dark_ff <= 1'b0;
         end
      end
   end

   assign center_x = cx_ff;
   assign center_y = cy_ff;
   assign dark_frame = dark_ff;

endmodule

@@ src/thresholded_gray_centroid_top.sv @@
// Top level of the thresholded gray centroid block.
// Depends on tgc_pkg, tgc_ctrl and tgc_datapath.
//
// Usage:
//   req_ channel carries BGR pixels in raster order, one beat per pixel;
//   req_tlast marks the final pixel of a frame. Each pixel is turned into
//   gray, thresholded and folded into intensity, column- and row-weighted
//   sums at one pixel per clock.
//   After the last pixel the input stalls while a shared restoring divider
//   forms both quotients, one bit per cycle.
//   The result beat appears on the rsp_ channel after the last pixel is
//   accepted and the flush, two loads, divide steps and capture are done; a dark
//   frame skips the divider and shows its beat after the flush and first load.
//   rsp_tuser flags a frame with zero total intensity; the centre is 0,0.
//   The result is held until rsp_tready; req_tready stays low meanwhile,
//   and the next frame is accepted in the cycle after the result beat.
//   The csr_ port writes threshold (index 0) and frame width (index 1);
//   write only while idle.
//   Synchronous reset restores threshold 20, width 640 and clears all sums.
module thresholded_gray_centroid_top #(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // blue[7:0], green[15:8], red[23:16]
   input  logic        req_tlast,   // last_pixel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // center_x[10:0], center_y[21:11], zero[23:22]
   output logic        rsp_tuser,   // dark_frame
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [11:0] csr_wdata
);
   import tgc_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic [COORD_W-1:0] center_x;
   logic [COORD_W-1:0] center_y;

   tgc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tgc_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .blue       (req_tdata[7:0]),
      .green      (req_tdata[15:8]),
      .red        (req_tdata[23:16]),
      .last_pixel (req_tlast),
      .center_x   (center_x),
      .center_y   (center_y),
      .dark_frame (rsp_tuser)
   );

   assign rsp_tdata = {2'b00, center_y, center_x};

endmodule

@@ src/tgc_checker.sv @@
// Port-level checks of the thresholded gray centroid block, bound to its top level.
// Depends on thresholded_gray_centroid_top.
module tgc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("pixel accepted while result pending");

   a_frame_end_stall: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready && !rsp_tvalid)
      else $error("frame end did not stall input");

   a_dark_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 24'd0)
      else $error("dark frame with nonzero centre");

endmodule

bind thresholded_gray_centroid_top tgc_checker u_tgc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
